FILE: hw/rtl/ppr_pkg.sv
// Shared types, codes and constants of the propeller pulse rate meter.
package ppr_pkg;

	localparam int StampBitsDef = 24;
	localparam int TsW          = 24;
	localparam int CountW       = 16;
	localparam int CalW         = 16;
	localparam int MinW         = 24;
	localparam int RateW        = 24;
	localparam int ScaleShift   = 7;
	localparam int NumW         = CountW + CalW + ScaleShift;
	localparam int StepW        = $clog2(NumW);
	localparam int CfgAddrW     = 2;
	localparam int CfgDataW     = 24;

	localparam logic [CalW-1:0] CalReset = CalW'(45613);
	localparam logic [MinW-1:0] MinReset = MinW'(32768);

	localparam logic [1:0] REQ_EDGE    = 2'd0;
	localparam logic [1:0] REQ_READ    = 2'd1;
	localparam logic [1:0] REQ_RESTART = 2'd2;

	localparam logic [CfgAddrW-1:0] CFG_CAL = CfgAddrW'(0);
	localparam logic [CfgAddrW-1:0] CFG_MIN = CfgAddrW'(1);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_MUL,
		ST_DIV,
		ST_DONE
	} state_t;

	typedef struct packed {
		logic edge_inc;
		logic read_start;
		logic restart;
		logic load_mul;
		logic div_step;
		logic load_out;
	} cmd_t;

	typedef struct packed {
		logic is_short;
		logic out_busy;
	} stat_t;

endpackage

FILE: hw/rtl/ppr_ctrl.sv
// Controller state machine: request decode, multiply, divide and result hand-off.
module ppr_ctrl
	import ppr_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	input  logic [1:0] req_type,
	output logic       in_ready,
	input  stat_t      stat,
	output cmd_t       cmd
);

	state_t            state_q;
	state_t            state_d;
	logic [StepW-1:0]  step_q;
	logic              take;
	logic              last_step;

	assign take      = in_valid && (state_q == ST_IDLE);
	assign last_step = (step_q == StepW'(NumW - 1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			step_q  <= '0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_DIV) begin
				step_q <= step_q + StepW'(1);
			end else begin
				step_q <= '0;
			end
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (take && req_type == REQ_READ) state_d = ST_MUL;
			end
			ST_MUL: begin
				state_d = stat.is_short ? ST_DONE : ST_DIV;
			end
			ST_DIV: begin
				if (last_step) state_d = ST_DONE;
			end
			ST_DONE: begin
				if (!stat.out_busy) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		in_ready       = 1'b0;
		cmd            = '0;
		case (state_q)
			ST_IDLE: begin
				in_ready       = 1'b1;
				cmd.edge_inc   = in_valid && req_type == REQ_EDGE;
				cmd.read_start = in_valid && req_type == REQ_READ;
				cmd.restart    = in_valid && req_type == REQ_RESTART;
			end
			ST_MUL:  cmd.load_mul = 1'b1;
			ST_DIV:  cmd.div_step = 1'b1;
			ST_DONE: cmd.load_out = !stat.out_busy;
			default: cmd = '0;
		endcase
	end

endmodule

FILE: hw/rtl/ppr_dp.sv
// Datapath: registers, edge counter, elapsed time, multiplier, restoring divider, output word.
module ppr_dp
	import ppr_pkg::*;
#(
	parameter int STAMP_BITS = StampBitsDef
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_we,
	input  logic [CfgAddrW-1:0] cfg_addr,
	input  logic [CfgDataW-1:0] cfg_wdata,
	input  logic [TsW-1:0]      time_stamp,
	input  cmd_t                cmd,
	output stat_t               stat,
	input  logic                out_ready,
	output logic                out_valid,
	output logic [RateW-1:0]    rate_q8,
	output logic                too_short
);

	localparam int CmpW = (STAMP_BITS > MinW) ? STAMP_BITS : MinW;

	logic [CalW-1:0]       cal_q;
	logic [MinW-1:0]       min_q;
	logic [CountW-1:0]     count_q;
	logic [STAMP_BITS-1:0] last_q;
	logic [CountW-1:0]     snap_q;
	logic [STAMP_BITS-1:0] elapsed_q;
	logic                  short_q;
	logic [NumW-1:0]       num_q;
	logic [STAMP_BITS-1:0] rem_q;
	logic                  out_valid_q;
	logic [RateW-1:0]      rate_q;
	logic                  too_short_q;

	logic [CmpW-1:0]       ts_ext;
	logic [STAMP_BITS-1:0] now;
	logic [STAMP_BITS-1:0] elapsed;
	logic                  short_now;
	logic [STAMP_BITS:0]   rem_sh;
	logic [STAMP_BITS:0]   rem_sub;
	logic                  q_bit;
	logic [CalW+CountW-1:0] prod;
	logic [RateW-1:0]      rate_sat;

	assign ts_ext    = CmpW'(time_stamp);
	assign now       = ts_ext[STAMP_BITS-1:0];
	assign elapsed   = now - last_q;
	assign short_now = (elapsed == '0) || (CmpW'(elapsed) < CmpW'(min_q));

	assign prod    = snap_q * cal_q;
	assign rem_sh  = {rem_q, num_q[NumW-1]};
	assign rem_sub = rem_sh - {1'b0, elapsed_q};
	assign q_bit   = !rem_sub[STAMP_BITS];

	// clamp quotients that do not fit the rate field
	assign rate_sat = (|num_q[NumW-1:RateW]) ? '1 : num_q[RateW-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cal_q       <= CalReset;
			min_q       <= MinReset;
			count_q     <= '0;
			last_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we && cfg_addr == CFG_CAL) cal_q <= cfg_wdata[CalW-1:0];
			if (cfg_we && cfg_addr == CFG_MIN) min_q <= cfg_wdata[MinW-1:0];
			if (cmd.edge_inc && count_q != '1) count_q <= count_q + CountW'(1);
			if (cmd.read_start || cmd.restart) begin
				count_q <= '0;
				last_q  <= now;
			end
			if (cmd.load_out) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.read_start) begin
			snap_q    <= count_q;
			elapsed_q <= elapsed;
			short_q   <= short_now;
		end
		if (cmd.load_mul) begin
			num_q <= {prod, ScaleShift'(0)};
			rem_q <= '0;
		end
		// one quotient bit per cycle, shifted in behind the dividend
		if (cmd.div_step) begin
			num_q <= {num_q[NumW-2:0], q_bit};
			rem_q <= q_bit ? rem_sub[STAMP_BITS-1:0] : rem_sh[STAMP_BITS-1:0];
		end
		if (cmd.load_out) begin
			rate_q      <= short_q ? '0 : rate_sat;
			too_short_q <= short_q;
		end
	end

	assign stat.is_short = short_q;
	assign stat.out_busy = out_valid_q && !out_ready;

	assign out_valid = out_valid_q;
	assign rate_q8   = rate_q;
	assign too_short = too_short_q;

endmodule

FILE: hw/rtl/propeller_pulse_rate_meter_top.sv
// Top level of the propeller pulse rate meter: controller plus datapath.
//
//  channel | signals                                   | moves
//  --------+-------------------------------------------+---------------------------
//  in      | in_valid, in_ready, req_type, time_stamp  | one request word
//  out     | out_valid, out_ready, rate_q8, too_short  | one rate word per read
//  cfg     | cfg_we, cfg_addr, cfg_wdata               | register write, no wait
//
// Edge and restart words are taken in the idle state. A read steps through capture,
// multiply, 39 divider steps and hand-off, and skips the divider steps when too short;
// the divider is a bit-serial restoring divider over the 39-bit numerator.
// Reset clears the count, the last time stamp and the output valid flag; registers
// return to their defaults. A read waits in its last state while the previous
// result is still held; the input side takes no new words until the read is done.
module propeller_pulse_rate_meter_top
	import ppr_pkg::*;
#(
	parameter int STAMP_BITS = StampBitsDef
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  logic [1:0]          req_type,
	input  logic [TsW-1:0]      time_stamp,
	output logic                out_valid,
	input  logic                out_ready,
	output logic [RateW-1:0]    rate_q8,
	output logic                too_short,
	input  logic                cfg_we,
	input  logic [CfgAddrW-1:0] cfg_addr,
	input  logic [CfgDataW-1:0] cfg_wdata
);

	cmd_t  cmd;
	stat_t stat;

	ppr_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.req_type (req_type),
		.in_ready (in_ready),
		.stat     (stat),
		.cmd      (cmd)
	);

	ppr_dp #(
		.STAMP_BITS (STAMP_BITS)
	) u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_addr   (cfg_addr),
		.cfg_wdata  (cfg_wdata),
		.time_stamp (time_stamp),
		.cmd        (cmd),
		.stat       (stat),
		.out_ready  (out_ready),
		.out_valid  (out_valid),
		.rate_q8    (rate_q8),
		.too_short  (too_short)
	);

endmodule

FILE: verif/testbench.sv
// Scoreboard-based testbench of the propeller pulse rate meter: directed, random and stall phases.
module testbench;
	import ppr_pkg::*;

	localparam int HoldCycles  = 1500;
	localparam int DrainCycles = 60;
	localparam int StallLimit  = 20000;

	localparam logic [1:0]          ReqUnused = 2'd3;
	localparam logic [CfgAddrW-1:0] CfgSpareA = CfgAddrW'(2);
	localparam logic [CfgAddrW-1:0] CfgSpareB = CfgAddrW'(3);

	typedef struct packed {
		logic [RateW-1:0] rate;
		logic             short_flag;
	} rate_word_t;

	// Tracks count, last stamp and registers; queues the rate word each read should give.
	class rate_scoreboard;
		logic [CalW-1:0]   cal;
		logic [MinW-1:0]   min_int;
		logic [CountW-1:0] edges;
		logic [TsW-1:0]    last_ts;
		rate_word_t        expected[$];
		int                errors;

		function new();
			cal     = CalReset;
			min_int = MinReset;
			edges   = '0;
			last_ts = '0;
			errors  = 0;
		endfunction

		function int pending();
			return expected.size();
		endfunction

		function void write_reg(logic [CfgAddrW-1:0] addr, logic [CfgDataW-1:0] data);
			case (addr)
				CFG_CAL: cal = data[CalW-1:0];
				CFG_MIN: min_int = data[MinW-1:0];
				default: ;
			endcase
		endfunction

		function void note_request(logic [1:0] req, logic [TsW-1:0] ts);
			logic [TsW-1:0] elapsed;
			logic [63:0]    num;
			logic [63:0]    quo;
			rate_word_t     word;
			case (req)
				REQ_EDGE: begin
					if (edges != '1) edges = edges + 1'b1;
				end
				REQ_RESTART: begin
					edges   = '0;
					last_ts = ts;
				end
				REQ_READ: begin
					elapsed = ts - last_ts;
					if (elapsed == '0 || elapsed < min_int) begin
						word.rate       = '0;
						word.short_flag = 1'b1;
					end else begin
						num = 64'(edges) * 64'(cal) * 64'd128;
						quo = num / 64'(elapsed);
						word.rate       = (quo > 64'hFF_FFFF) ? '1 : quo[RateW-1:0];
						word.short_flag = 1'b0;
					end
					expected.push_back(word);
					edges   = '0;
					last_ts = ts;
				end
				default: ;
			endcase
		endfunction

		task report_mismatch(string msg);
			$display("MISMATCH: %s", msg);
			errors++;
		endtask

		task check_rate(logic [RateW-1:0] rate, logic short_flag);
			rate_word_t want;
			if (expected.size() == 0) begin
				report_mismatch($sformatf("rate word %0d short %0b with none pending",
					rate, short_flag));
				return;
			end
			want = expected.pop_front();
			if (rate !== want.rate)
				report_mismatch($sformatf("rate_q8 got %0d want %0d", rate, want.rate));
			if (short_flag !== want.short_flag)
				report_mismatch($sformatf("too_short got %0b want %0b",
					short_flag, want.short_flag));
		endtask
	endclass

	logic                clk        = 1'b0;
	logic                arst_n     = 1'b0;
	logic                in_valid   = 1'b0;
	logic                in_ready;
	logic [1:0]          req_type   = '0;
	logic [TsW-1:0]      time_stamp = '0;
	logic                out_valid;
	logic                out_ready  = 1'b0;
	logic [RateW-1:0]    rate_q8;
	logic                too_short;
	logic                cfg_we     = 1'b0;
	logic [CfgAddrW-1:0] cfg_addr   = '0;
	logic [CfgDataW-1:0] cfg_wdata  = '0;

	int tx_idle_pct = 0;
	int rx_idle_pct = 0;
	int hold_req    = 0;
	int hold_served = 0;

	rate_scoreboard sb;

	propeller_pulse_rate_meter_top i_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.req_type   (req_type),
		.time_stamp (time_stamp),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.rate_q8    (rate_q8),
		.too_short  (too_short),
		.cfg_we     (cfg_we),
		.cfg_addr   (cfg_addr),
		.cfg_wdata  (cfg_wdata)
	);

	always #6 clk = ~clk;

	// Check results before noting requests so the older expectation is always at the front.
	always @(posedge clk) begin
		if (out_valid && out_ready) sb.check_rate(rate_q8, too_short);
		if (in_valid && in_ready) sb.note_request(req_type, time_stamp);
	end

	initial begin : watchdog
		int quiet;
		quiet = 0;
		while (quiet < StallLimit) begin
			@(posedge clk);
			if ((in_valid && in_ready) || (out_valid && out_ready)) quiet = 0;
			else quiet++;
		end
		$display("Some tests failed");
		$finish;
	end

	// Receiver: random stalls, or one long hold-off per request.
	initial begin : receiver
		forever begin
			@(negedge clk);
			if (hold_served != hold_req) begin
				hold_served++;
				out_ready <= 1'b0;
				repeat (HoldCycles - 1) @(negedge clk);
			end else begin
				out_ready <= ($urandom_range(99) >= rx_idle_pct);
			end
		end
	end

	// Returns right after the accepting edge; valid stays high for a following word.
	task automatic send_word(logic [1:0] req, logic [TsW-1:0] ts);
		@(negedge clk);
		while (tx_idle_pct > 0 && $urandom_range(99) < tx_idle_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid   <= 1'b1;
		req_type   <= req;
		time_stamp <= ts;
		do @(posedge clk); while (!in_ready);
	endtask

	// Drop valid, wait for all pending rate words, then let the block go quiet.
	task automatic settle(int extra);
		@(negedge clk);
		in_valid <= 1'b0;
		while (sb.pending() != 0) @(negedge clk);
		repeat (extra) @(negedge clk);
	endtask

	task automatic write_reg(logic [CfgAddrW-1:0] addr, logic [CfgDataW-1:0] data);
		cfg_we    <= 1'b1;
		cfg_addr  <= addr;
		cfg_wdata <= data;
		sb.write_reg(addr, data);
		@(negedge clk);
		cfg_we <= 1'b0;
		@(negedge clk);
	endtask

	task automatic run_random(int n);
		int             sent;
		int             k;
		int unsigned    wide;
		logic [1:0]     req;
		logic [TsW-1:0] gap;
		sent = 0;
		while (sent < n) begin
			if ($urandom_range(99) < 80) begin
				if ($urandom_range(3) != 0) begin
					send_word(REQ_RESTART, TsW'($urandom));
					sent++;
				end
				k = ($urandom_range(9) == 0) ? $urandom_range(300) : $urandom_range(24);
				repeat (k) send_word(REQ_EDGE, TsW'($urandom));
				sent += k;
				// Aim the read around the minimum interval, sometimes anywhere.
				case ($urandom_range(9))
					0: gap = '0;
					1: gap = sb.min_int - 1'b1;
					2: gap = sb.min_int;
					3: gap = TsW'($urandom_range(int'(sb.min_int)));
					9: gap = TsW'($urandom);
					default: begin
						wide = int'(sb.min_int) + $urandom_range(4 * int'(sb.min_int) + 64);
						gap  = (wide > 32'hFF_FFFF) ? '1 : TsW'(wide);
					end
				endcase
				send_word(REQ_READ, sb.last_ts + gap);
				sent++;
			end else begin
				req = 2'($urandom);
				send_word(req, TsW'($urandom));
				if (req != ReqUnused) sent++;
			end
			if ($urandom_range(39) == 0) settle(0);
		end
	endtask

	initial begin : stimulus
		sb = new();
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Directed words under the reset register values.
		send_word(REQ_READ, '0);
		send_word(REQ_RESTART, TsW'(100));
		for (int i = 0; i < 5; i++) send_word(REQ_EDGE, i[0] ? '1 : '0);
		send_word(REQ_READ, TsW'(100 + 32768));
		send_word(REQ_READ, TsW'(100 + 32768 + 32767));
		send_word(REQ_RESTART, 24'hFF_FF00);
		repeat (3) send_word(REQ_EDGE, 24'h5A_5A5A);
		send_word(REQ_READ, 24'h00_7F00);
		send_word(ReqUnused, '1);
		send_word(ReqUnused, '0);
		send_word(REQ_EDGE, 24'hA5_A5A5);
		send_word(REQ_READ, '1);
		send_word(REQ_RESTART, 24'hAA_AAAA);
		send_word(REQ_EDGE, 24'h12_3456);
		send_word(REQ_READ, 24'h55_5555);
		settle(DrainCycles);

		// Spare indexes must not disturb anything; calibration data is masked to 16 bits.
		write_reg(CfgSpareA, '1);
		write_reg(CfgSpareB, '1);
		write_reg(CFG_CAL, '1);
		write_reg(CFG_MIN, CfgDataW'(1));
		send_word(REQ_RESTART, '0);
		repeat (40) send_word(REQ_EDGE, '1);
		send_word(REQ_READ, TsW'(1));
		send_word(REQ_READ, TsW'(1));

		// Long edge run over a nearly full-range interval.
		send_word(REQ_RESTART, 24'h80_0000);
		repeat (300) send_word(REQ_EDGE, TsW'($urandom));
		send_word(REQ_READ, 24'h7F_FFFF);
		settle(DrainCycles);

		// Zero minimum interval: zero elapsed is still too short.
		write_reg(CFG_MIN, '0);
		send_word(REQ_READ, 24'h7F_FFFF);
		send_word(REQ_EDGE, '0);
		send_word(REQ_READ, 24'h80_0000);

		for (int ph = 0; ph < 4; ph++) begin
			settle(DrainCycles);
			case (ph)
				0: begin
					tx_idle_pct = 0;
					rx_idle_pct = 0;
					write_reg(CFG_CAL, CfgDataW'($urandom));
					write_reg(CFG_MIN, CfgDataW'($urandom_range(4096, 1)));
				end
				1: begin
					tx_idle_pct = 83;
					rx_idle_pct = 0;
					write_reg(CFG_CAL, CfgDataW'(24'hFF_0000));
					write_reg(CFG_MIN, '1);
				end
				2: begin
					tx_idle_pct = 0;
					rx_idle_pct = 83;
					write_reg(CFG_CAL, '1);
					write_reg(CFG_MIN, CfgDataW'($urandom_range(100000, 1)));
				end
				default: begin
					tx_idle_pct = 21;
					rx_idle_pct = 21;
					write_reg(CFG_CAL, CfgDataW'(CalReset));
					write_reg(CFG_MIN, CfgDataW'(MinReset));
				end
			endcase
			run_random(330);
			if (ph == 0) begin
				// Hold the output off while reads keep coming, so the input backs up.
				hold_req++;
				repeat (12) begin
					send_word(REQ_RESTART, TsW'($urandom));
					repeat (2) send_word(REQ_EDGE, TsW'($urandom));
					send_word(REQ_READ, sb.last_ts + sb.min_int + TsW'($urandom_range(255)));
				end
				settle(0);
			end
		end

		settle(DrainCycles);
		if (sb.errors == 0 && sb.pending() == 0) begin
			$display("All tests passed");
		end else begin
			$display("Some tests failed");
		end
		$finish;
	end

endmodule
